>>> rtl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

    // Request kinds carried in the low bits of s_axis_tuser
    localparam logic [1:0] FUNC_KEY     = 2'd0;
    localparam logic [1:0] FUNC_KEY_END = 2'd1;
    localparam logic [1:0] FUNC_ENC     = 2'd2;
    localparam logic [1:0] FUNC_DEC     = 2'd3;

    localparam int LETTER_W  = 5;
    localparam int COORD_W   = 3;
    localparam int ALPHA_N   = 26;
    localparam int CELLS_N   = 25;
    localparam int TDATA_W   = 16;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Q = 5'd16;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    localparam logic [COORD_W-1:0] SQ_LAST = 3'd4;
    localparam logic [COORD_W-1:0] SQ_SIDE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XLATE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } coord_t;

    // Square write broadcast to every lane
    typedef struct packed {
        logic                en;
        logic [LETTER_W-1:0] letter;
        coord_t              slot;
    } lane_wr_t;

    // Saturate to z, fold j into i
    function automatic logic [LETTER_W-1:0] norm_letter(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] c;
        c = (v > LETTER_Z) ? LETTER_Z : v;
        if (c == LETTER_J)
        begin
            c = LETTER_I;
        end
        return c;
    endfunction

    // row * 5 + col, both below 5
    function automatic logic [LETTER_W-1:0] cell_index(input coord_t p);
        return LETTER_W'({p.row, 2'b00}) + LETTER_W'(p.row) + LETTER_W'(p.col);
    endfunction

    // One step around the square, forward or back
    function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] v,
                                                     input logic fwd);
        logic [COORD_W-1:0] r;
        if (fwd)
        begin
            r = (v == SQ_LAST) ? '0 : v + 3'd1;
        end
        else
        begin
            r = (v == '0) ? SQ_LAST : v - 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/playfair_digraph_cipher_core.sv
`default_nettype none

// Channel   Dir  tdata (low bit up)                   tuser (low bit up)
// s_axis    in   first_letter[4:0], second_letter     func[1:0], has_second[2]
//                [9:5], zero pad [15:10]
// m_axis    out  out_first[4:0], out_second[9:5],     status[0]
//                zero pad [15:10]
//
// Steps: key letter, written when taken; key end (request, then one alphabet
// letter per cycle); pair (lane table lookup, then merge and square read into the
// output register). One request is worked on at a time; the lookup/fill sequencer
// sets the rate. Reset clears the FSM, presence bits, fill counters and output valid;
// square and position tables hold garbage until a key is loaded.
// A stalled m_axis holds the result; a pair waiting behind it stays in the merge step.
module playfair_digraph_cipher_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output      logic                         s_axis_tready,
    input  wire logic [pfc_pkg::TDATA_W-1:0]  s_axis_tdata,  // first_letter, second_letter
    input  wire logic [2:0]                   s_axis_tuser,  // func, has_second
    output      logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output      logic [pfc_pkg::TDATA_W-1:0]  m_axis_tdata,  // out_first, out_second
    output      logic [0:0]                   m_axis_tuser   // status
);

    // request fields
    logic [1:0]                   func;
    logic [pfc_pkg::LETTER_W-1:0] in_first;
    logic [pfc_pkg::LETTER_W-1:0] in_second;
    logic                         has_second;
    logic                         accept;

    assign func       = s_axis_tuser[1:0];
    assign has_second = s_axis_tuser[2];
    assign in_first   = pfc_pkg::norm_letter(s_axis_tdata[4:0]);
    assign in_second  = has_second ? pfc_pkg::norm_letter(s_axis_tdata[9:5])
                                   : pfc_pkg::LETTER_Q;
    assign accept     = s_axis_tvalid && s_axis_tready;

    // control state
    pfc_pkg::state_t              state_reg, state_next;
    logic [pfc_pkg::ALPHA_N-1:0]  present_reg, present_next;
    pfc_pkg::coord_t              fill_reg, fill_next;       // next free cell
    logic                         complete_reg, complete_next;
    logic [pfc_pkg::LETTER_W-1:0] fill_letter_reg, fill_letter_next;
    logic                         fwd_reg, fwd_next;
    logic                         bad_reg, bad_next;         // pair before square done

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [pfc_pkg::LETTER_W-1:0] out_first_reg, out_first_next;
    logic [pfc_pkg::LETTER_W-1:0] out_second_reg, out_second_next;
    logic                         status_reg, status_next;

    // FSM outputs
    logic key_go;
    logic end_go;
    logic pair_go;
    logic fill_active;
    logic xlate_go;

    // square writer
    logic                         clear_key;
    logic [pfc_pkg::ALPHA_N-1:0]  present_eff;
    pfc_pkg::coord_t              fill_eff;
    logic [pfc_pkg::LETTER_W-1:0] add_letter;
    logic                         add_try;
    pfc_pkg::lane_wr_t            wr;

    // lanes and merge
    pfc_pkg::coord_t              coord0, coord1;
    pfc_pkg::coord_t              tgt0, tgt1;
    logic [pfc_pkg::LETTER_W-1:0] lane0_letter, lane1_letter;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == pfc_pkg::FUNC_ENC || func == pfc_pkg::FUNC_DEC)
                    begin
                        state_next = pfc_pkg::ST_XLATE;
                    end
                    else if (func == pfc_pkg::FUNC_KEY_END && !complete_reg)
                    begin
                        state_next = pfc_pkg::ST_FILL;
                    end
                end
            end
            pfc_pkg::ST_XLATE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_FILL:
            begin
                if (fill_letter_reg == pfc_pkg::LETTER_Z)
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        key_go        = 1'b0;
        end_go        = 1'b0;
        pair_go       = 1'b0;
        fill_active   = 1'b0;
        xlate_go      = 1'b0;
        unique case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                key_go        = s_axis_tvalid && (func == pfc_pkg::FUNC_KEY);
                end_go        = s_axis_tvalid && (func == pfc_pkg::FUNC_KEY_END);
                pair_go       = s_axis_tvalid && func[1];
            end
            pfc_pkg::ST_XLATE:
            begin
                xlate_go = !out_valid_reg || m_axis_tready;
            end
            pfc_pkg::ST_FILL:
            begin
                fill_active = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Square writer: a key letter after completion starts a fresh key.
    assign clear_key   = key_go && complete_reg;
    assign present_eff = clear_key ? '0 : present_reg;
    assign fill_eff    = clear_key ? '0 : fill_reg;
    assign add_letter  = fill_active ? fill_letter_reg : in_first;
    assign add_try     = key_go || (fill_active && fill_letter_reg != pfc_pkg::LETTER_J);

    always_comb
    begin
        wr.en     = add_try && !present_eff[add_letter] && (fill_eff.row != pfc_pkg::SQ_SIDE);
        wr.letter = add_letter;
        wr.slot   = fill_eff;

        present_next = present_eff;
        fill_next    = fill_eff;
        if (wr.en)
        begin
            present_next = present_eff | (pfc_pkg::ALPHA_N'(1) << add_letter);
            if (fill_eff.col == pfc_pkg::SQ_LAST)
            begin
                fill_next = '{row: fill_eff.row + 3'd1, col: '0};
            end
            else
            begin
                fill_next = '{row: fill_eff.row, col: fill_eff.col + 3'd1};
            end
        end

        complete_next = complete_reg;
        if (clear_key)
        begin
            complete_next = 1'b0;
        end
        else if (fill_active && fill_letter_reg == pfc_pkg::LETTER_Z)
        begin
            complete_next = 1'b1;
        end

        fill_letter_next = fill_letter_reg;
        if (end_go)
        begin
            fill_letter_next = '0;
        end
        else if (fill_active)
        begin
            fill_letter_next = fill_letter_reg + 5'd1;
        end

        fwd_next = pair_go ? (func == pfc_pkg::FUNC_ENC) : fwd_reg;
        bad_next = pair_go ? !complete_reg : bad_reg;
    end

    pfc_lane u_lane0 (
        .clk          (clk),
        .wr           (wr),
        .capture      (pair_go),
        .lookup_letter(in_first),
        .coord        (coord0),
        .rd_cell      (tgt0),
        .rd_letter    (lane0_letter)
    );

    pfc_lane u_lane1 (
        .clk          (clk),
        .wr           (wr),
        .capture      (pair_go),
        .lookup_letter(in_second),
        .coord        (coord1),
        .rd_cell      (tgt1),
        .rd_letter    (lane1_letter)
    );

    pfc_merge u_merge (
        .c0 (coord0),
        .c1 (coord1),
        .fwd(fwd_reg),
        .t0 (tgt0),
        .t1 (tgt1)
    );

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        status_next     = status_reg;
        if (xlate_go)
        begin
            out_valid_next  = 1'b1;
            out_first_next  = bad_reg ? '0 : lane0_letter;
            out_second_next = bad_reg ? '0 : lane1_letter;
            status_next     = bad_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfc_pkg::ST_IDLE;
            present_reg     <= '0;
            fill_reg        <= '0;
            complete_reg    <= 1'b0;
            fill_letter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            present_reg     <= present_next;
            fill_reg        <= fill_next;
            complete_reg    <= complete_next;
            fill_letter_reg <= fill_letter_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg        <= fwd_next;
        bad_reg        <= bad_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        status_reg     <= status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_second_reg, out_first_reg};
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

>>> rtl/pfc_lane.sv
`default_nettype none

// One letter lane: own copy of the square and of the letter-to-cell table.
module pfc_lane (
    input  wire logic                          clk,
    input  wire pfc_pkg::lane_wr_t             wr,
    input  wire logic                          capture,
    input  wire logic [pfc_pkg::LETTER_W-1:0]  lookup_letter,
    output      pfc_pkg::coord_t               coord,
    input  wire pfc_pkg::coord_t               rd_cell,
    output      logic [pfc_pkg::LETTER_W-1:0]  rd_letter
);

    pfc_pkg::coord_t            pos_mem [pfc_pkg::ALPHA_N];
    logic [pfc_pkg::LETTER_W-1:0] square_mem [pfc_pkg::CELLS_N];
    pfc_pkg::coord_t            coord_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pos_mem[wr.letter]                       <= wr.slot;
            square_mem[pfc_pkg::cell_index(wr.slot)] <= wr.letter;
        end
        if (capture)
        begin
            coord_reg <= pos_mem[lookup_letter];
        end
    end

    assign coord     = coord_reg;
    assign rd_letter = square_mem[pfc_pkg::cell_index(rd_cell)];

endmodule

`default_nettype wire

>>> rtl/pfc_merge.sv
`default_nettype none

// Combines both lane coordinates into the two target cells.
module pfc_merge (
    input  wire pfc_pkg::coord_t c0,
    input  wire pfc_pkg::coord_t c1,
    input  wire logic            fwd,
    output      pfc_pkg::coord_t t0,
    output      pfc_pkg::coord_t t1
);

    always_comb
    begin
        priority if (c0.col == c1.col)
        begin
            t0 = '{row: pfc_pkg::wrap_step(c0.row, fwd), col: c0.col};
            t1 = '{row: pfc_pkg::wrap_step(c1.row, fwd), col: c1.col};
        end
        else if (c0.row == c1.row)
        begin
            t0 = '{row: c0.row, col: pfc_pkg::wrap_step(c0.col, fwd)};
            t1 = '{row: c1.row, col: pfc_pkg::wrap_step(c1.col, fwd)};
        end
        else
        begin
            // rectangle: swap columns
            t0 = '{row: c0.row, col: c1.col};
            t1 = '{row: c1.row, col: c0.col};
        end
    end

endmodule

`default_nettype wire

>>> rtl/pfc_checker.sv
`default_nettype none

module pfc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic [2:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // invalid-square result carries zero letters
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'h0000)
        else $error("status set with nonzero letters");

    // a good result never shows j or a code beyond z
    a_letters: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[4:0] != 5'd9 && m_axis_tdata[9:5] != 5'd9 &&
            m_axis_tdata[4:0] <= 5'd25 && m_axis_tdata[9:5] <= 5'd25 &&
            m_axis_tdata[15:10] == 6'd0)
        else $error("bad letter code in result");

    // a pair request is worked on alone
    a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[1] |=> !s_axis_tready)
        else $error("request taken during pair lookup");

endmodule

bind playfair_digraph_cipher_core pfc_checker u_pfc_checker (.*);

`default_nettype wire
